// ===== design/hiqp_pkg.sv =====
// Package: shared constants, state and status types for the quadratic-probe hash insert block.
package hiqp_pkg;

    localparam int MAX_SLOTS  = 1024;
    localparam int SLOT_W     = $clog2(MAX_SLOTS);
    localparam int SIZE_W     = SLOT_W + 1;
    localparam int CFG_W      = 11;
    localparam int KEY_W      = 31;
    localparam int ENTRY_W    = KEY_W + 1;
    localparam int CNT_W      = $clog2(KEY_W);
    localparam int STATUS_W   = 2;

    localparam logic [CFG_W-1:0]  SIZE_RESET = CFG_W'(1021);
    localparam logic [SIZE_W-1:0] SIZE_MIN   = SIZE_W'(2);
    localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_SLOTS);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_READ,
        S_CHECK,
        S_DONE
    } t_state;

    typedef enum logic [STATUS_W-1:0] {
        STAT_NEW     = 2'd0,
        STAT_PRESENT = 2'd1,
        STAT_NONE    = 2'd2
    } t_status;

endpackage

// ===== design/hiqp_ram.sv =====
// Generic single-port RAM with registered read data.
module hiqp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/hash_insert_quadratic_probe.sv =====
// Top level: hash table insert with positive quadratic probing over one slot memory.
//
//  channel   dir  handshake            payload
//  -------   ---  -------------------  -------------------------
//  input     in   i_valid / o_stall    i_key
//  result    out  o_valid / i_stall    o_slot, o_status
//  config    in   i_cfg_we             i_cfg_data (table size)
//
// An item takes an accept, a bit-serial key mod size over the KEY_W (31) key
// bits, a memory read, then a check per probe (up to size/2), then a load into
// the output register.
// Probes are bound by the single memory port, one entry looked at per cycle.
// After reset a clearing pass writes every one of MAX_SLOTS entries with
// o_stall high. A finished result waits in the output register while the
// next item is accepted; the block only holds at its end if that register
// is still full and i_stall is high.
module hash_insert_quadratic_probe
    import hiqp_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [CFG_W-1:0]    i_cfg_data,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [KEY_W-1:0]    i_key,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [SLOT_W-1:0]   o_slot,
    output logic [STATUS_W-1:0] o_status
);

    t_state r_state, n_state;

    logic [CFG_W-1:0]  r_table_size;
    logic [SLOT_W-1:0] r_clr_idx, n_clr_idx;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic [KEY_W-1:0]  r_key, n_key;
    logic [KEY_W-1:0]  r_shift, n_shift;
    logic [SIZE_W-1:0] r_size, n_size;
    logic [SIZE_W-1:0] r_rem, n_rem;
    logic [SLOT_W-1:0] r_last, n_last;
    logic [SLOT_W-1:0] r_probe, n_probe;
    logic [SLOT_W-1:0] r_pos, n_pos;
    logic [SLOT_W-1:0] r_step, n_step;
    logic [SLOT_W-1:0] r_res_slot, n_res_slot;
    t_status           r_res_status, n_res_status;
    logic              r_out_valid, n_out_valid;
    logic [SLOT_W-1:0] r_out_slot, n_out_slot;
    t_status           r_out_status, n_out_status;

    logic [SIZE_W-1:0]  w_eff_size;
    logic [SIZE_W-1:0]  w_div_t;
    logic [SIZE_W-1:0]  w_div_rem;
    logic [SIZE_W-1:0]  w_pos_sum;
    logic [SLOT_W-1:0]  w_pos_next;
    logic [SIZE_W-1:0]  w_step_sum;
    logic [SLOT_W-1:0]  w_step_next;
    logic               w_used;
    logic               w_match;
    logic               w_accept;
    logic               w_out_free;

    logic               w_we;
    logic [SLOT_W-1:0]  w_addr;
    logic [ENTRY_W-1:0] w_wdata;
    logic [ENTRY_W-1:0] w_rdata;

    // entry layout: used bit on top, key below
    hiqp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_wdata),
        .o_rdata (w_rdata)
    );

    // clamp configured size to [2, MAX_SLOTS]
    always_comb begin
        w_eff_size = SIZE_W'(r_table_size);
        if (r_table_size < CFG_W'(SIZE_MIN)) begin
            w_eff_size = SIZE_MIN;
        end else if (r_table_size > CFG_W'(SIZE_MAX)) begin
            w_eff_size = SIZE_MAX;
        end
    end

    // one restoring-division step, key MSB first
    assign w_div_t   = {r_rem[SLOT_W-1:0], r_shift[KEY_W-1]};
    assign w_div_rem = (w_div_t >= r_size) ? (w_div_t - r_size) : w_div_t;

    // pos(i+1) = pos(i) + (2i+1), step(i+1) = step(i) + 2, both kept below size
    assign w_pos_sum   = SIZE_W'(r_pos) + SIZE_W'(r_step);
    assign w_pos_next  = (w_pos_sum >= r_size) ? SLOT_W'(w_pos_sum - r_size)
                                               : SLOT_W'(w_pos_sum);
    assign w_step_sum  = SIZE_W'(r_step) + SIZE_W'(2);
    assign w_step_next = (w_step_sum >= r_size) ? SLOT_W'(w_step_sum - r_size)
                                                : SLOT_W'(w_step_sum);

    assign w_used  = w_rdata[KEY_W];
    assign w_match = (w_rdata[KEY_W-1:0] == r_key);

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= SIZE_RESET;
        end else if (i_cfg_we) begin
            r_table_size <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_idx   <= '0;
            r_cnt       <= '0;
            r_probe     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_cnt       <= n_cnt;
            r_probe     <= n_probe;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key        <= n_key;
        r_shift      <= n_shift;
        r_size       <= n_size;
        r_rem        <= n_rem;
        r_last       <= n_last;
        r_pos        <= n_pos;
        r_step       <= n_step;
        r_res_slot   <= n_res_slot;
        r_res_status <= n_res_status;
        r_out_slot   <= n_out_slot;
        r_out_status <= n_out_status;
    end

    always_comb begin
        n_state      = r_state;
        n_clr_idx    = r_clr_idx;
        n_cnt        = r_cnt;
        n_key        = r_key;
        n_shift      = r_shift;
        n_size       = r_size;
        n_rem        = r_rem;
        n_last       = r_last;
        n_probe      = r_probe;
        n_pos        = r_pos;
        n_step       = r_step;
        n_res_slot   = r_res_slot;
        n_res_status = r_res_status;
        n_out_valid  = r_out_valid;
        n_out_slot   = r_out_slot;
        n_out_status = r_out_status;
        w_we         = 1'b0;
        w_addr       = r_pos;
        w_wdata      = {1'b1, r_key};

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                w_we      = 1'b1;
                w_addr    = r_clr_idx;
                w_wdata   = '0;
                n_clr_idx = r_clr_idx + SLOT_W'(1);
                if (r_clr_idx == SLOT_W'(MAX_SLOTS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_accept) begin
                    n_key   = i_key;
                    n_shift = i_key;
                    n_rem   = '0;
                    n_cnt   = '0;
                    n_size  = w_eff_size;
                    n_last  = SLOT_W'((w_eff_size >> 1) - SIZE_W'(1));
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                n_rem   = w_div_rem;
                n_shift = r_shift << 1;
                n_cnt   = r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(KEY_W - 1)) begin
                    n_pos   = SLOT_W'(w_div_rem);
                    n_step  = SLOT_W'(1);
                    n_probe = '0;
                    n_state = S_READ;
                end
            end
            S_READ: begin
                w_addr  = r_pos;
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (!w_used) begin
                    w_we         = 1'b1;
                    w_addr       = r_pos;
                    n_res_slot   = r_pos;
                    n_res_status = STAT_NEW;
                    n_state      = S_DONE;
                end else if (w_match) begin
                    n_res_slot   = r_pos;
                    n_res_status = STAT_PRESENT;
                    n_state      = S_DONE;
                end else if (r_probe == r_last) begin
                    n_res_slot   = '0;
                    n_res_status = STAT_NONE;
                    n_state      = S_DONE;
                end else begin
                    // read the next probe slot while this one is checked
                    w_addr  = w_pos_next;
                    n_pos   = w_pos_next;
                    n_step  = w_step_next;
                    n_probe = r_probe + SLOT_W'(1);
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_slot   = r_res_slot;
                    n_out_status = r_res_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_valid  = r_out_valid;
    assign o_slot   = r_out_slot;
    assign o_status = r_out_status;

    // probe address always lies inside the table in use
    a_pos_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (SIZE_W'(r_pos) < r_size))
        else $error("probe slot beyond table size");

    // probe count never runs past half the table
    a_probe_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> (r_probe <= r_last))
        else $error("probe count past limit");

    // memory is written only by the clearing pass or an insert
    a_write_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_we |-> (r_state == S_CLEAR || r_state == S_CHECK))
        else $error("unexpected slot memory write");

    // a result leaves the done state only into a free output register
    a_done_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE && n_state == S_IDLE) |=> (o_valid && o_status == $past(r_res_status)))
        else $error("result not loaded into output register");

endmodule

// ===== dv/tb_hash_insert_quadratic_probe.sv =====
// Testbench for the quadratic-probe hash insert block: directed rows, then random key phases.
module tb_hash_insert_quadratic_probe;
    import hiqp_pkg::*;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } t_insert_res;

    typedef enum logic {ROW_KEY, ROW_CFG} t_row_kind;

    typedef struct packed {
        t_row_kind         kind;
        logic [CFG_W-1:0]  size;
        logic [KEY_W-1:0]  key;
        logic              chk;
        logic [SLOT_W-1:0] slot;
        t_status           status;
    } t_row;

    localparam int NUM_ITEMS = 1170;
    localparam int NUM_ROWS  = 27;
    localparam logic [KEY_W-1:0] KEY_ONES = '1;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFG_W-1:0]    i_cfg_data;
    logic                i_valid;
    logic                o_stall;
    logic [KEY_W-1:0]    i_key;
    logic                o_valid;
    logic                i_stall;
    logic [SLOT_W-1:0]   o_slot;
    logic [STATUS_W-1:0] o_status;

    // shadow of the table and the size register
    logic [CFG_W-1:0] size_reg = SIZE_RESET;
    bit               used_map [MAX_SLOTS];
    logic [KEY_W-1:0] key_map  [MAX_SLOTS];

    t_insert_res      insert_q [$];
    logic [KEY_W-1:0] recent_keys [$];
    int               mismatch_cnt = 0;
    int               n_sent = 0;
    logic             idle_on = 1'b1;

    int prime_sizes [18] = '{2, 3, 5, 7, 11, 13, 17, 19, 23, 29, 31, 37, 41, 61, 67, 97, 101, 127};
    int edge_sizes  [8]  = '{0, 1, 2, 2047, 1024, 1021, 1023, 1500};
    int big_sizes   [4]  = '{251, 509, 1021, 1024};

    // expected slot is typed in only where it follows directly from earlier rows
    t_row dir_rows [NUM_ROWS] = '{
        '{ROW_KEY, 11'd0,    31'd0,           1'b1, 10'd0,    STAT_NEW},
        '{ROW_KEY, 11'd0,    31'd0,           1'b1, 10'd0,    STAT_PRESENT},
        '{ROW_KEY, 11'd0,    31'd1021,        1'b1, 10'd1,    STAT_NEW},
        '{ROW_KEY, 11'd0,    31'd2042,        1'b1, 10'd4,    STAT_NEW},
        '{ROW_KEY, 11'd0,    31'h7FFF_FFFF,   1'b1, 10'd53,   STAT_NEW},
        '{ROW_KEY, 11'd0,    31'h7FFF_FFFF,   1'b1, 10'd53,   STAT_PRESENT},
        '{ROW_CFG, 11'd0,    31'd0,           1'b0, 10'd0,    STAT_NEW},
        '{ROW_KEY, 11'd0,    31'd0,           1'b1, 10'd0,    STAT_PRESENT},
        '{ROW_KEY, 11'd0,    31'd2,           1'b1, 10'd0,    STAT_NONE},
        '{ROW_KEY, 11'd0,    31'd1,           1'b1, 10'd0,    STAT_NONE},
        '{ROW_CFG, 11'd1,    31'd0,           1'b0, 10'd0,    STAT_NEW},
        '{ROW_KEY, 11'd0,    31'd1021,        1'b1, 10'd1,    STAT_PRESENT},
        '{ROW_CFG, 11'd2047, 31'd0,           1'b0, 10'd0,    STAT_NEW},
        '{ROW_KEY, 11'd0,    31'd1024,        1'b1, 10'd9,    STAT_NEW},
        '{ROW_KEY, 11'd0,    31'h7FFF_FFFF,   1'b1, 10'd1023, STAT_NEW},
        '{ROW_CFG, 11'd1024, 31'd0,           1'b0, 10'd0,    STAT_NEW},
        '{ROW_KEY, 11'd0,    31'd2048,        1'b0, 10'd0,    STAT_NEW},
        '{ROW_KEY, 11'd0,    31'h7FFF_FFFF,   1'b1, 10'd1023, STAT_PRESENT},
        '{ROW_CFG, 11'd3,    31'd0,           1'b0, 10'd0,    STAT_NEW},
        '{ROW_KEY, 11'd0,    31'd3,           1'b1, 10'd0,    STAT_NONE},
        '{ROW_KEY, 11'd0,    31'd5,           1'b1, 10'd2,    STAT_NEW},
        '{ROW_CFG, 11'd5,    31'd0,           1'b0, 10'd0,    STAT_NEW},
        '{ROW_KEY, 11'd0,    31'd5,           1'b1, 10'd0,    STAT_NONE},
        '{ROW_KEY, 11'd0,    31'd6,           1'b0, 10'd0,    STAT_NEW},
        '{ROW_KEY, 11'd0,    31'd3,           1'b1, 10'd3,    STAT_NEW},
        '{ROW_CFG, 11'd1021, 31'd0,           1'b0, 10'd0,    STAT_NEW},
        '{ROW_KEY, 11'd0,    31'd1024,        1'b0, 10'd0,    STAT_NEW}
    };

    hash_insert_quadratic_probe dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_key      (i_key),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_slot     (o_slot),
        .o_status   (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int eff_size(input logic [CFG_W-1:0] v);
        if (v < SIZE_MIN) return int'(SIZE_MIN);
        if (v > SIZE_MAX) return int'(SIZE_MAX);
        return int'(v);
    endfunction

    // insert into the shadow table, return slot and status
    function automatic t_insert_res probe_insert(input logic [KEY_W-1:0] key);
        t_insert_res res;
        int          sz;
        int          home;
        int          pos;
        int          i;
        bit          hit;
        sz = eff_size(size_reg);
        home = int'({1'b0, key} % 32'(sz));
        res.slot = '0;
        res.status = STAT_NONE;
        hit = 1'b0;
        for (i = 0; i < sz / 2 && !hit; i++) begin
            pos = (home + i * i) % sz;
            if (!used_map[pos]) begin
                used_map[pos] = 1'b1;
                key_map[pos] = key;
                res.slot = SLOT_W'(pos);
                res.status = STAT_NEW;
                hit = 1'b1;
            end else if (key_map[pos] == key) begin
                res.slot = SLOT_W'(pos);
                res.status = STAT_PRESENT;
                hit = 1'b1;
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < 100) $display("ERROR at %0t: %s", $time, msg);
        mismatch_cnt++;
    endtask

    task automatic send_key(input logic [KEY_W-1:0] key, input logic chk,
                            input logic [SLOT_W-1:0] slot, input t_status status);
        t_insert_res res;
        idle_on <= !(n_sent >= 450 && n_sent < 700);
        while (idle_on && $urandom_range(0, 99) < 10) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_key   <= key;
        do @(posedge i_clk); while (o_stall);
        res = probe_insert(key);
        if (chk) begin
            res.slot = slot;
            res.status = status;
        end
        insert_q.push_back(res);
        n_sent++;
        recent_keys.push_back(key);
        if (recent_keys.size() > 64) void'(recent_keys.pop_front());
    endtask

    // never returns without waiting on the clock, so the next drive lands in a later step
    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (insert_q.size() != 0);
    endtask

    task automatic write_size(input logic [CFG_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        size_reg = v;
    endtask

    always @(posedge i_clk) begin
        i_stall <= idle_on && ($urandom_range(0, 99) < 10);
    end

    always @(posedge i_clk) begin : result_check
        t_insert_res want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (insert_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result slot=%0d status=%0d",
                                          o_slot, o_status));
            end else begin
                want = insert_q.pop_front();
                if (o_slot !== want.slot)
                    report_mismatch($sformatf("slot %0d, expected %0d", o_slot, want.slot));
                if (o_status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              o_status, want.status));
            end
        end
    end

    initial begin : stim
        int               r;
        int               sz;
        int               burst;
        logic [KEY_W-1:0] key;
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_key      = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[n]) begin
            if (dir_rows[n].kind == ROW_CFG) begin
                drain_results();
                write_size(dir_rows[n].size);
            end else begin
                send_key(dir_rows[n].key, dir_rows[n].chk, dir_rows[n].slot,
                         dir_rows[n].status);
            end
        end

        while (n_sent < NUM_ITEMS) begin
            // new size only once the table has gone quiet
            drain_results();
            r = $urandom_range(0, 19);
            if (r == 0)
                write_size(CFG_W'(edge_sizes[$urandom_range(0, 7)]));
            else if (r == 1)
                write_size(CFG_W'(big_sizes[$urandom_range(0, 3)]));
            else
                write_size(CFG_W'(prime_sizes[$urandom_range(0, 17)]));
            sz = eff_size(size_reg);
            burst = $urandom_range(15, 60);
            repeat (burst) begin
                r = $urandom_range(0, 99);
                if (r < 35)
                    key = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
                else if (r < 70)
                    key = KEY_W'($urandom_range(0, sz - 1) + sz * $urandom_range(0, 15));
                else if (r < 90)
                    key = KEY_W'($urandom);
                else if (r < 95)
                    key = KEY_ONES - KEY_W'($urandom_range(0, 3));
                else
                    key = KEY_W'($urandom_range(0, 3));
                send_key(key, 1'b0, '0, STAT_NEW);
                if ($urandom_range(0, 49) == 0) drain_results();
            end
        end

        drain_results();
        repeat (600) @(posedge i_clk);
        if (mismatch_cnt == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #80_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
